### rtl/core/gdlm_pkg.sv
// Shared types, states and saturating helpers of the Gaussian dual line maximizer.
package gdlm_pkg;

	localparam int VAL_W = 64;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] PT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] V48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] V48_MIN = -64'sh0000_8000_0000_0000;

	localparam logic [1:0] STAT_FINITE = 2'd0;
	localparam logic [1:0] STAT_UNBOUNDED = 2'd1;
	localparam logic [1:0] STAT_UNDEF = 2'd2;
	localparam logic [1:0] STAT_SAT = 2'd3;

	// A 64-bit value together with its saturation flag.
	typedef struct packed {
		logic sat;
		logic signed [63:0] v;
	} sval_t;

	typedef enum logic [4:0] {
		ST_ACC, ST_MAC, ST_SCALE, ST_DE, ST_BRANCH, ST_CD, ST_CDAB, ST_DD,
		ST_DDAA, ST_CC, ST_CCBB, ST_DIV1, ST_SQRT, ST_DIV2, ST_XAB, ST_XX,
		ST_XXBB, ST_XD, ST_CHK, ST_DIV3, ST_EX, ST_FIN, ST_EMIT
	} state_t;

	// Magnitude of a signed value as unsigned.
	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		mag64 = x[63] ? 64'(-x) : 64'(x);
	endfunction

	// Signed value from a magnitude and sign, clamped to the positive limit.
	function automatic sval_t from_mag(input logic [63:0] m, input logic neg);
		sval_t r;
		logic [63:0] mm;
		mm = m[63] ? 64'(S64_MAX) : m;
		r.sat = m[63];
		r.v = neg ? -$signed(mm) : $signed(mm);
		from_mag = r;
	endfunction

	// Saturating add.
	function automatic sval_t sadd(input logic signed [63:0] a, input logic signed [63:0] b);
		sval_t r;
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		r.sat = s[64] != s[63];
		r.v = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
		sadd = r;
	endfunction

	// Saturating subtract.
	function automatic sval_t ssub(input logic signed [63:0] a, input logic signed [63:0] b);
		sval_t r;
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		r.sat = s[64] != s[63];
		r.v = r.sat ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
		ssub = r;
	endfunction

endpackage

### rtl/core/gdlm_mul.sv
// Shift-and-add fractional multiplier, one multiplier bit per cycle.
module gdlm_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] res,
	output logic               sat,
	output logic               done,
	output logic               busy
);

	logic         run_q;
	logic         fin_q;
	logic         done_q;
	logic [5:0]   cnt_q;
	logic [127:0] p_q;
	logic [63:0]  mc_q;
	logic         neg_q;
	logic signed [63:0] res_q;
	logic         sat_q;

	logic [64:0]  step_sum;
	logic [127:0] shifted;
	logic [63:0]  lo;
	gdlm_pkg::sval_t fm;

	// One partial product per cycle and the final scaling.
	always_comb begin
		step_sum = {1'b0, p_q[127:64]} + (p_q[0] ? {1'b0, mc_q} : 65'd0);
		shifted = p_q >> FRAC_BITS;
		lo = (|shifted[127:64]) ? '1 : shifted[63:0];
		fm = gdlm_pkg::from_mag(lo, neg_q);
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Product register and result.
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= gdlm_pkg::mag64(a);
			p_q <= {64'd0, gdlm_pkg::mag64(b)};
			neg_q <= a[63] ^ b[63];
		end else if (run_q) begin
			p_q <= {step_sum, p_q[63:1]};
		end
		if (fin_q) begin
			res_q <= fm.v;
			sat_q <= fm.sat;
		end
	end

	assign res = res_q;
	assign sat = sat_q;
	assign done = done_q;
	assign busy = run_q | fin_q | done_q;

endmodule

### rtl/core/gdlm_dsq.sv
// Restoring fractional divider and square root, one quotient or root bit per cycle.
module gdlm_dsq #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               sqrt_mode,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] res,
	output logic               sat,
	output logic               done,
	output logic               busy
);

	logic         run_q;
	logic         fin_q;
	logic         done_q;
	logic [6:0]   cnt_q;
	logic         mode_q;
	logic         neg_q;
	logic [127:0] num_q;
	logic [127:0] q_q;
	logic [66:0]  r_q;
	logic [63:0]  dm_q;
	logic signed [63:0] res_q;
	logic         sat_q;

	logic [64:0]  div_rem;
	logic         div_ge;
	logic [66:0]  sq_rem;
	logic [66:0]  sq_trial;
	logic         sq_ge;
	logic         last_step;
	logic [63:0]  lo;
	gdlm_pkg::sval_t fm;

	// One restoring step of either operation.
	always_comb begin
		div_rem = {r_q[63:0], num_q[127]};
		div_ge = div_rem >= {1'b0, dm_q};
		sq_rem = {r_q[64:0], num_q[127:126]};
		sq_trial = {1'b0, q_q[63:0], 2'b01};
		sq_ge = sq_rem >= sq_trial;
		last_step = mode_q ? (cnt_q == 7'd63) : (cnt_q == 7'd127);
		lo = (!mode_q && (|q_q[127:64])) ? '1 : q_q[63:0];
		fm = gdlm_pkg::from_mag(lo, neg_q);
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (last_step) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, quotient and result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {64'd0, gdlm_pkg::mag64(a)} << FRAC_BITS;
			dm_q <= gdlm_pkg::mag64(b);
			r_q <= '0;
			q_q <= '0;
			mode_q <= sqrt_mode;
			neg_q <= sqrt_mode ? 1'b0 : (a[63] ^ b[63]);
		end else if (run_q) begin
			if (mode_q) begin
				r_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
				q_q <= {q_q[126:0], sq_ge};
				num_q <= {num_q[125:0], 2'b00};
			end else begin
				r_q <= {2'b00, (div_ge ? (div_rem - {1'b0, dm_q}) : div_rem)};
				q_q <= {q_q[126:0], div_ge};
				num_q <= {num_q[126:0], 1'b0};
			end
		end
		if (fin_q) begin
			res_q <= fm.v;
			sat_q <= fm.sat;
		end
	end

	assign res = res_q;
	assign sat = sat_q;
	assign done = done_q;
	assign busy = run_q | fin_q | done_q;

endmodule

### rtl/core/gauss_dual_line_maximizer_core.sv
// Top level: dot-product accumulation and the sequencer of the line maximization.
//
//   channel  | dir | payload
//   s_*      | in  | tdata: a_elem, b_elem, coef_c, coef_d, coef_e, coef_f; tlast: last_elem
//   m_*      | out | tdata: best_point, best_value; tuser: status
//
// Each element is accepted in ST_ACC and then forms its three products on the shared 24x24 multiplier in ST_MAC.
// The last element adds the maximization: up to twelve multiplies, three divides
// and a root on the iterative units.
// Reset clears the sums, the element count and all handshake state.
// s_tready is low while the sequencer works; a result waiting on m_tready does not
// block the next vector, only the next result.
module gauss_dual_line_maximizer_core #(
	parameter int MAX_DIM = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // a_elem, b_elem, coef_c, coef_d, coef_e, coef_f
	input  logic         s_tlast,  // last_elem
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // best_point, best_value, zero pad
	output logic [1:0]   m_tuser   // status
);

	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam logic signed [63:0] ROUND_M = (64'sd1 <<< FRAC_BITS) - 64'sd1;

	gdlm_pkg::state_t st_q, st_d;

	logic busy_q;
	logic out_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] k_q;
	logic en_q;
	logic last_q;
	logic signed [23:0] a_q, b_q;
	logic signed [55:0] sum_aa_q, sum_bb_q, sum_ab_q;

	logic signed [63:0] aa_q, bb_q, ab_q, c_q, d_q, e_q, f_q;
	logic signed [63:0] delta_q, t_q, u_q, big_q, x_q, n_q, den_q, v_q;
	logic sat_q;
	logic [30:0] pt_q;
	logic [47:0] val_q;
	logic [1:0] stat_q;
	logic [30:0] m_pt_q;
	logic [47:0] m_val_q;
	logic [1:0] m_stat_q;

	logic mul_go, dsq_go, dsq_sqrt, op_unit;
	logic signed [63:0] opa, opb;
	logic signed [63:0] mul_res, dsq_res, u_res;
	logic mul_sat, dsq_sat, u_sat;
	logic mul_done, dsq_done, u_done;
	logic mul_busy, dsq_busy;
	logic signed [63:0] cap_v;
	logic cap_s;
	gdlm_pkg::sval_t t1, t2;
	logic out_free;
	logic accept;
	logic signed [23:0] mx, my;
	logic signed [47:0] prod;
	logic signed [55:0] prod56;
	logic signed [63:0] sx_aa, sx_bb, sx_ab;

	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign u_done = mul_done | dsq_done;
	assign u_res = dsq_done ? dsq_res : mul_res;
	assign u_sat = dsq_done ? dsq_sat : mul_sat;

	gdlm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(opa), .b(opb),
		.res(mul_res), .sat(mul_sat), .done(mul_done), .busy(mul_busy)
	);

	gdlm_dsq #(.FRAC_BITS(FRAC_BITS)) u_dsq (
		.clk(clk), .arst_n(arst_n), .start(dsq_go), .sqrt_mode(dsq_sqrt), .a(opa), .b(opb),
		.res(dsq_res), .sat(dsq_sat), .done(dsq_done), .busy(dsq_busy)
	);

	// Element multiplier: one of the three products per cycle.
	always_comb begin
		unique case (k_q)
			2'd0: begin mx = a_q; my = a_q; end
			2'd1: begin mx = b_q; my = b_q; end
			default: begin mx = a_q; my = b_q; end
		endcase
		prod = mx * my;
		prod56 = 56'(prod);
		sx_aa = 64'(sum_aa_q);
		sx_bb = 64'(sum_bb_q);
		sx_ab = 64'(sum_ab_q);
	end

	// Sequencer: operand selection, next state and the value captured from the units.
	always_comb begin
		st_d = st_q;
		op_unit = 1'b0;
		dsq_sqrt = 1'b0;
		opa = '0;
		opb = '0;
		cap_v = u_res;
		cap_s = u_sat;
		t1 = gdlm_pkg::sadd(u_res, u_res);
		t2 = gdlm_pkg::sadd(bb_q, t1.v);
		unique case (st_q)
			gdlm_pkg::ST_ACC: if (accept) st_d = gdlm_pkg::ST_MAC;
			gdlm_pkg::ST_MAC: begin
				if (k_q == 2'd2) st_d = last_q ? gdlm_pkg::ST_SCALE : gdlm_pkg::ST_ACC;
			end
			gdlm_pkg::ST_SCALE: st_d = gdlm_pkg::ST_DE;
			gdlm_pkg::ST_DE: begin
				opa = d_q; opb = e_q;
				cap_v = t2.v; cap_s = u_sat | t1.sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_BRANCH;
			end
			gdlm_pkg::ST_BRANCH: begin
				if (delta_q < 0) begin
					st_d = (d_q < 0) ? gdlm_pkg::ST_XAB : gdlm_pkg::ST_EMIT;
				end else begin
					st_d = (d_q == 0 || delta_q == 0) ? gdlm_pkg::ST_EMIT : gdlm_pkg::ST_CD;
				end
			end
			gdlm_pkg::ST_CD: begin
				opa = c_q; opb = d_q;
				if (u_done) st_d = gdlm_pkg::ST_CDAB;
			end
			gdlm_pkg::ST_CDAB: begin
				opa = t_q; opb = ab_q;
				if (u_done) st_d = gdlm_pkg::ST_DD;
			end
			gdlm_pkg::ST_DD: begin
				opa = d_q; opb = d_q;
				if (u_done) st_d = gdlm_pkg::ST_DDAA;
			end
			gdlm_pkg::ST_DDAA: begin
				opa = u_q; opb = aa_q;
				t1 = gdlm_pkg::sadd(t_q, t_q);
				t2 = gdlm_pkg::ssub(u_res, t1.v);
				cap_v = t2.v; cap_s = u_sat | t1.sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_CC;
			end
			gdlm_pkg::ST_CC: begin
				opa = c_q; opb = c_q;
				if (u_done) st_d = gdlm_pkg::ST_CCBB;
			end
			gdlm_pkg::ST_CCBB: begin
				opa = u_q; opb = bb_q;
				t2 = gdlm_pkg::sadd(big_q, u_res);
				cap_v = t2.v[63] ? 64'sd0 : t2.v; cap_s = u_sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_DIV1;
			end
			gdlm_pkg::ST_DIV1: begin
				op_unit = 1'b1; opa = big_q; opb = delta_q;
				if (u_done) st_d = gdlm_pkg::ST_SQRT;
			end
			gdlm_pkg::ST_SQRT: begin
				op_unit = 1'b1; dsq_sqrt = 1'b1; opa = u_q;
				t2 = gdlm_pkg::ssub(u_res, c_q);
				cap_v = t2.v; cap_s = u_sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_DIV2;
			end
			gdlm_pkg::ST_DIV2: begin
				op_unit = 1'b1; opa = u_q; opb = d_q;
				if (u_res < 0) begin
					cap_v = '0;
				end else if (u_res > gdlm_pkg::PT_MAX) begin
					cap_v = gdlm_pkg::PT_MAX; cap_s = 1'b1;
				end
				if (u_done) st_d = gdlm_pkg::ST_XAB;
			end
			gdlm_pkg::ST_XAB: begin
				opa = x_q; opb = ab_q;
				t2 = gdlm_pkg::sadd(aa_q, t1.v);
				cap_v = t2.v; cap_s = u_sat | t1.sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_XX;
			end
			gdlm_pkg::ST_XX: begin
				opa = x_q; opb = x_q;
				if (u_done) st_d = gdlm_pkg::ST_XXBB;
			end
			gdlm_pkg::ST_XXBB: begin
				opa = u_q; opb = bb_q;
				t2 = gdlm_pkg::sadd(t_q, u_res);
				cap_v = t2.v; cap_s = u_sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_XD;
			end
			gdlm_pkg::ST_XD: begin
				opa = x_q; opb = d_q;
				t2 = gdlm_pkg::sadd(c_q, u_res);
				cap_v = t2.v; cap_s = u_sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_CHK;
			end
			gdlm_pkg::ST_CHK: st_d = (den_q == 0) ? gdlm_pkg::ST_EMIT : gdlm_pkg::ST_DIV3;
			gdlm_pkg::ST_DIV3: begin
				op_unit = 1'b1; opa = n_q; opb = den_q;
				cap_v = -($signed(u_res + 64'(u_res[63])) >>> 1);
				if (u_done) st_d = gdlm_pkg::ST_EX;
			end
			gdlm_pkg::ST_EX: begin
				opa = e_q; opb = x_q;
				t2 = gdlm_pkg::ssub(v_q, u_res);
				cap_v = t2.v; cap_s = u_sat | t2.sat;
				if (u_done) st_d = gdlm_pkg::ST_FIN;
			end
			gdlm_pkg::ST_FIN: begin
				t2 = gdlm_pkg::ssub(v_q, f_q);
				cap_v = t2.v; cap_s = t2.sat;
				if (t2.v > gdlm_pkg::V48_MAX) begin
					cap_v = gdlm_pkg::V48_MAX; cap_s = 1'b1;
				end else if (t2.v < gdlm_pkg::V48_MIN) begin
					cap_v = gdlm_pkg::V48_MIN; cap_s = 1'b1;
				end
				st_d = gdlm_pkg::ST_EMIT;
			end
			gdlm_pkg::ST_EMIT: if (out_free) st_d = gdlm_pkg::ST_ACC;
			default: st_d = gdlm_pkg::ST_ACC;
		endcase
	end

	// Issue to a unit once per arithmetic state.
	always_comb begin
		mul_go = 1'b0;
		dsq_go = 1'b0;
		unique case (st_q)
			gdlm_pkg::ST_ACC, gdlm_pkg::ST_MAC, gdlm_pkg::ST_SCALE, gdlm_pkg::ST_BRANCH,
			gdlm_pkg::ST_CHK, gdlm_pkg::ST_FIN, gdlm_pkg::ST_EMIT: ;
			default: begin
				mul_go = !busy_q && !op_unit;
				dsq_go = !busy_q && op_unit;
			end
		endcase
	end

	// State, accumulation control and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gdlm_pkg::ST_ACC;
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			k_q <= '0;
			sum_aa_q <= '0;
			sum_bb_q <= '0;
			sum_ab_q <= '0;
		end else begin
			st_q <= st_d;
			if (mul_go || dsq_go) busy_q <= 1'b1;
			else if (u_done) busy_q <= 1'b0;
			if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			if (st_q == gdlm_pkg::ST_EMIT && out_free) out_valid_q <= 1'b1;
			if (accept) k_q <= '0;
			if (st_q == gdlm_pkg::ST_MAC) begin
				k_q <= k_q + 2'd1;
				if (en_q) begin
					unique case (k_q)
						2'd0: sum_aa_q <= sum_aa_q + prod56;
						2'd1: sum_bb_q <= sum_bb_q + prod56;
						default: begin
							sum_ab_q <= sum_ab_q + prod56;
							cnt_q <= cnt_q + CNT_W'(1);
						end
					endcase
				end
			end
			if (st_q == gdlm_pkg::ST_SCALE) begin
				sum_aa_q <= '0;
				sum_bb_q <= '0;
				sum_ab_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	// Datapath registers of the maximization.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= s_tdata[23:0];
			b_q <= s_tdata[47:24];
			c_q <= 64'($signed(s_tdata[71:48]));
			d_q <= 64'($signed(s_tdata[95:72]));
			e_q <= 64'($signed(s_tdata[119:96]));
			f_q <= 64'($signed(s_tdata[143:120]));
			last_q <= s_tlast;
			en_q <= cnt_q < CNT_W'(MAX_DIM);
		end
		if (u_done) sat_q <= sat_q | cap_s;
		unique case (st_q)
			gdlm_pkg::ST_SCALE: begin
				aa_q <= (sx_aa + (sx_aa[63] ? ROUND_M : 64'sd0)) >>> FRAC_BITS;
				bb_q <= (sx_bb + (sx_bb[63] ? ROUND_M : 64'sd0)) >>> FRAC_BITS;
				ab_q <= (sx_ab + (sx_ab[63] ? ROUND_M : 64'sd0)) >>> FRAC_BITS;
				sat_q <= 1'b0;
				pt_q <= '0;
				val_q <= '0;
				stat_q <= gdlm_pkg::STAT_UNDEF;
			end
			gdlm_pkg::ST_DE: if (u_done) delta_q <= cap_v;
			gdlm_pkg::ST_BRANCH: begin
				x_q <= '0;
				if (delta_q < 0 && d_q > 0) begin
					pt_q <= '1;
					val_q <= gdlm_pkg::V48_MAX[47:0];
					stat_q <= gdlm_pkg::STAT_UNBOUNDED;
				end
			end
			gdlm_pkg::ST_CD, gdlm_pkg::ST_CDAB, gdlm_pkg::ST_XAB: if (u_done) t_q <= cap_v;
			gdlm_pkg::ST_DD, gdlm_pkg::ST_CC, gdlm_pkg::ST_DIV1, gdlm_pkg::ST_SQRT,
			gdlm_pkg::ST_XX: if (u_done) u_q <= cap_v;
			gdlm_pkg::ST_DDAA, gdlm_pkg::ST_CCBB: if (u_done) big_q <= cap_v;
			gdlm_pkg::ST_DIV2: if (u_done) x_q <= cap_v;
			gdlm_pkg::ST_XXBB: if (u_done) n_q <= cap_v;
			gdlm_pkg::ST_XD: if (u_done) den_q <= cap_v;
			gdlm_pkg::ST_DIV3, gdlm_pkg::ST_EX: if (u_done) v_q <= cap_v;
			gdlm_pkg::ST_FIN: begin
				pt_q <= x_q[30:0];
				val_q <= cap_v[47:0];
				stat_q <= (sat_q | cap_s) ? gdlm_pkg::STAT_SAT : gdlm_pkg::STAT_FINITE;
			end
			gdlm_pkg::ST_EMIT: begin
				if (out_free) begin
					m_pt_q <= pt_q;
					m_val_q <= val_q;
					m_stat_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = st_q == gdlm_pkg::ST_ACC;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, m_val_q, m_pt_q};
	assign m_tuser = m_stat_q;

	// Input is taken only while the sequencer is parked.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> st_q == gdlm_pkg::ST_ACC)
		else $error("input ready outside accumulation");

	// The two arithmetic units never start together nor while one is running.
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_go || dsq_go) |-> !(mul_go && dsq_go) && !mul_busy && !dsq_busy)
		else $error("arithmetic unit issued while busy");

	// An unbounded result carries the saturated argmax.
	a_unbounded: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == gdlm_pkg::STAT_UNBOUNDED) |-> (&m_tdata[30:0]))
		else $error("unbounded result without saturated argmax");

endmodule

### tb/gdlm_checker.sv
// Checker for the line maximizer: tracks input beats, predicts results and compares them.
`timescale 1ns / 1ps

module gdlm_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [79:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	output int           errors,
	output int           pending
);

	localparam int MAX_DIM = 256;
	localparam int FRAC = 16;

	typedef struct {
		logic [30:0] point;
		logic [47:0] value;
		logic [1:0]  status;
	} optimum_t;

	optimum_t optimum_q[$];
	logic signed [63:0] dot_aa, dot_bb, dot_ab;
	int elems;
	logic clipped;

	assign pending = optimum_q.size();

	function automatic logic [63:0] abs64(input logic signed [63:0] x);
		return x[63] ? ~x + 64'd1 : x;
	endfunction

	// Signed value from a magnitude, clipped to the positive 64-bit limit.
	function automatic logic signed [63:0] signed_of(input logic [63:0] m, input bit neg);
		if (m > 64'h7FFF_FFFF_FFFF_FFFF) begin
			m = 64'h7FFF_FFFF_FFFF_FFFF;
			clipped = 1'b1;
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			clipped = 1'b1;
			return s[64] ? gdlm_pkg::S64_MIN : gdlm_pkg::S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			clipped = 1'b1;
			return s[64] ? gdlm_pkg::S64_MIN : gdlm_pkg::S64_MAX;
		end
		return s[63:0];
	endfunction

	// Fixed-point product, truncated toward zero.
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic [127:0] p;
		logic [63:0] m;
		p = (128'(abs64(x)) * 128'(abs64(y))) >> FRAC;
		m = (p[127:64] != 0) ? '1 : p[63:0];
		return signed_of(m, x[63] != y[63]);
	endfunction

	// Fixed-point quotient, truncated toward zero; y is never zero here.
	function automatic logic signed [63:0] fx_div(input logic signed [63:0] x,
			input logic signed [63:0] y);
		logic [127:0] q;
		logic [63:0] m;
		q = (128'(abs64(x)) << FRAC) / 128'(abs64(y));
		m = (q[127:64] != 0) ? '1 : q[63:0];
		return signed_of(m, x[63] != y[63]);
	endfunction

	// Fixed-point square root, rounded down.
	function automatic logic signed [63:0] fx_sqrt(input logic signed [63:0] r);
		logic [127:0] n;
		logic [63:0] y, t;
		n = 128'(abs64(r)) << FRAC;
		y = 0;
		for (int b = 63; b >= 0; b--) begin
			t = y | (64'd1 << b);
			if (128'(t) * 128'(t) <= n)
				y = t;
		end
		return signed_of(y, 1'b0);
	endfunction

	// Maximize g along the line from the finished dot products.
	function automatic optimum_t maximize(input logic signed [63:0] c, input logic signed [63:0] d,
			input logic signed [63:0] e, input logic signed [63:0] f);
		optimum_t o;
		logic signed [63:0] aa, bb, ab, delta, x, n, den, v, t, big, s, root;
		aa = dot_aa / 64'sd65536;
		bb = dot_bb / 64'sd65536;
		ab = dot_ab / 64'sd65536;
		clipped = 1'b0;
		o.point = '0;
		o.value = '0;
		o.status = gdlm_pkg::STAT_UNDEF;
		t = fx_mul(d, e);
		delta = add_clip(bb, add_clip(t, t));
		if (delta < 0) begin
			if (d > 0) begin
				o.point = 31'h7FFF_FFFF;
				o.value = 48'h7FFF_FFFF_FFFF;
				o.status = gdlm_pkg::STAT_UNBOUNDED;
				return o;
			end
			if (d == 0)
				return o;
			x = 0;
		end else begin
			if (d == 0 || delta == 0)
				return o;
			t = fx_mul(fx_mul(c, d), ab);
			big = sub_clip(fx_mul(fx_mul(d, d), aa), add_clip(t, t));
			big = add_clip(big, fx_mul(fx_mul(c, c), bb));
			if (big < 0)
				big = 0;
			s = fx_sqrt(fx_div(big, delta));
			root = fx_div(sub_clip(s, c), d);
			x = root < 0 ? 64'sd0 : root;
			if (x > gdlm_pkg::PT_MAX) begin
				x = gdlm_pkg::PT_MAX;
				clipped = 1'b1;
			end
		end
		t = fx_mul(x, ab);
		n = add_clip(add_clip(aa, add_clip(t, t)), fx_mul(fx_mul(x, x), bb));
		den = add_clip(c, fx_mul(x, d));
		if (den == 0)
			return o;
		v = -(fx_div(n, den) / 64'sd2);
		v = sub_clip(sub_clip(v, fx_mul(e, x)), f);
		if (v > gdlm_pkg::V48_MAX) begin
			v = gdlm_pkg::V48_MAX;
			clipped = 1'b1;
		end
		if (v < gdlm_pkg::V48_MIN) begin
			v = gdlm_pkg::V48_MIN;
			clipped = 1'b1;
		end
		o.point = x[30:0];
		o.value = v[47:0];
		o.status = clipped ? gdlm_pkg::STAT_SAT : gdlm_pkg::STAT_FINITE;
		return o;
	endfunction

	// Accumulate each accepted input beat and predict on the last element.
	always @(posedge clk or negedge arst_n) begin
		logic signed [63:0] a, b;
		if (!arst_n) begin
			dot_aa = 0;
			dot_bb = 0;
			dot_ab = 0;
			elems = 0;
		end else if (s_tvalid && s_tready) begin
			a = 64'(signed'(s_tdata[23:0]));
			b = 64'(signed'(s_tdata[47:24]));
			if (elems < MAX_DIM) begin
				dot_aa = dot_aa + a * a;
				dot_bb = dot_bb + b * b;
				dot_ab = dot_ab + a * b;
				elems = elems + 1;
			end
			if (s_tlast) begin
				optimum_q.push_back(maximize(64'(signed'(s_tdata[71:48])),
					64'(signed'(s_tdata[95:72])), 64'(signed'(s_tdata[119:96])),
					64'(signed'(s_tdata[143:120]))));
				dot_aa = 0;
				dot_bb = 0;
				dot_ab = 0;
				elems = 0;
			end
		end
	end

	// Compare each accepted result beat with the oldest prediction.
	initial errors = 0;
	always @(posedge clk) begin
		optimum_t o;
		if (arst_n && m_tvalid && m_tready) begin
			if (optimum_q.size() == 0) begin
				$display("%0t: unexpected result point=%h value=%h status=%0d",
					$time, m_tdata[30:0], m_tdata[78:31], m_tuser);
				errors = errors + 1;
			end else begin
				o = optimum_q.pop_front();
				if (m_tdata[30:0] !== o.point || m_tdata[78:31] !== o.value ||
						m_tuser !== o.status) begin
					$display("%0t: expected point=%h value=%h status=%0d, got %h %h %0d",
						$time, o.point, o.value, o.status,
						m_tdata[30:0], m_tdata[78:31], m_tuser);
					errors = errors + 1;
				end
			end
		end
	end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, stimulus and final verdict for the line maximizer.
`timescale 1ns / 1ps

module tb;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [79:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           errors;
	int           pending;
	bit           calm;
	bit           hold_req;
	int           quiet_cycles;

	gauss_dual_line_maximizer_core dut (.*);
	gdlm_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Random 24-bit field: full range, moderate, or an extreme.
	function automatic logic [23:0] pick24(input int kind);
		case (kind)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 1048576)) - 524288);
			2: return 24'($signed($urandom_range(0, 65536)) - 32768);
			default: begin
				case ($urandom_range(0, 3))
					0: return 24'h800000;
					1: return 24'h7FFFFF;
					2: return 24'h000000;
					default: return 24'hFFFFFF;
				endcase
			end
		endcase
	endfunction

	// Offer one beat and wait until it is taken; optionally idle before it.
	task automatic push_beat(input logic [23:0] a, input logic [23:0] b, input logic [23:0] c,
			input logic [23:0] d, input logic [23:0] e, input logic [23:0] f, input bit last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {f, e, d, c, b, a};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// One vector with random elements; coefficients ride on every beat.
	task automatic push_vector(input int len, input int kind);
		logic [23:0] c, d, e, f;
		c = pick24($urandom_range(0, 9) == 0 ? 0 : kind);
		d = pick24($urandom_range(0, 9) == 0 ? 3 : kind);
		e = pick24($urandom_range(0, 9) == 0 ? 0 : kind);
		f = pick24($urandom_range(0, 9) == 0 ? 0 : kind);
		for (int i = 0; i < len; i++)
			push_beat(pick24(kind), pick24(kind), c, d, e, f, i == len - 1);
	endtask

	initial begin
		int sent;
		int len;
		bit held;
		bit drained;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		calm = 0;
		hold_req = 0;
		held = 0;
		drained = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: finite, unbounded, x at zero, undefined cases, extremes.
		push_beat(24'h010000, 24'h020000, 24'h010000, 24'h008000, 24'h004000, 24'h001000, 1);
		// Negative delta with positive slope: unbounded.
		push_beat(24'h000100, 24'h000100, 24'h010000, 24'h010000, 24'hF00000, 24'h0, 1);
		// Negative delta with negative slope: argmax at zero.
		push_beat(24'h010000, 24'h000100, 24'h020000, 24'hFF0000, 24'h100000, 24'h0, 1);
		// Positive delta with zero slope: undefined.
		push_beat(24'h010000, 24'h000100, 24'h020000, 24'h000000, 24'h100000, 24'h0, 1);
		// Zero delta in the root case: undefined.
		push_beat(24'h000000, 24'h000000, 24'h010000, 24'h010000, 24'h000000, 24'h0, 1);
		// Zero denominator at the argmax.
		push_beat(24'h010000, 24'h000100, 24'h000000, 24'hFF0000, 24'h100000, 24'h0, 1);
		// Zero slope with positive delta: undefined.
		push_beat(24'h010000, 24'h010000, 24'h010000, 24'h000000, 24'h010000, 24'h0, 1);
		// Extreme fields and a multi-element vector driving saturation.
		push_beat(24'h800000, 24'h7FFFFF, 24'h000001, 24'h000001, 24'h7FFFFF, 24'h800000, 0);
		push_beat(24'h7FFFFF, 24'h800000, 24'h000001, 24'h000001, 24'h7FFFFF, 24'h800000, 1);
		push_beat(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1);
		push_beat(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1);
		push_beat(24'h000001, 24'h7FFFFF, 24'h000001, 24'h7FFFFF, 24'h000000, 24'h000000, 1);
		sent = 12;

		// Random vectors, mostly short; two run past the element limit.
		while (sent < 1850) begin
			if (sent > 1550)
				calm = 1;
			if (sent > 300 && sent < 320) begin
				len = 257 + $urandom_range(0, 3);
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(7, 16);
			end else begin
				len = $urandom_range(1, 6);
			end
			if (sent > 700 && sent < 720)
				len = 257;
			if (!held && sent > 900) begin
				// Long receiver hold while the sender keeps offering.
				held = 1;
				hold_req = 1;
				repeat (4) begin
					push_vector(2, 1);
					sent += 2;
				end
			end
			if (!drained && sent > 1200) begin
				drained = 1;
				s_tvalid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			push_vector(len, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3));
			sent += len;
		end
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (2000) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
